@@ hdl/sgdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgdt_pkg
// Types and constants shared by the Sobel gradient double threshold block.
// ----------------------------------------------------------------------------
package sgdt_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCFG_W = 11;
  localparam int HCFG_W = 13;
  localparam int THR_W  = 21;
  localparam int MAG_W  = 21;
  localparam int SQ_W   = 20;
  localparam int GRAD_W = 11;
  localparam int CLS_W  = 2;

  // line store holds the upper and middle rows side by side
  localparam int LINE_W = 2 * PIX_W;

  // window queue between front and back
  localparam int MQ_DEPTH = 8;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);

  // result queue at the output
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR_SQ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR_SQ  = 2'd3;

  localparam logic [WCFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [HCFG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [THR_W-1:0]  RST_LOW_THR_SQ   = 21'd4900;
  localparam logic [THR_W-1:0]  RST_HIGH_THR_SQ  = 21'd19600;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [CLS_W-1:0] edge_class;
    logic [MAG_W-1:0] magnitude_sq;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
  } out_item_t;

  // one 3x3 window, row major, entry 0 top left
  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    logic [ROW_W-1:0]      center_row;
    logic [COL_W-1:0]      center_col;
  } win_item_t;

endpackage
`default_nettype wire

@@ hdl/sgdt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/sgdt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgdt_front
// Raster position tracking, line store and 3x3 window; hands interior
// windows to the window queue.
// ----------------------------------------------------------------------------
module sgdt_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire sgdt_pkg::in_item_t             in_data,
  output logic                                in_full,
  input  wire logic [sgdt_pkg::WCFG_W-1:0]    image_width,
  input  wire logic [sgdt_pkg::HCFG_W-1:0]    image_height,
  input  wire logic [sgdt_pkg::MQ_CW-1:0]     mq_level,
  output logic                                mq_push,
  output sgdt_pkg::win_item_t                 mq_item
);

  localparam int COL_W  = sgdt_pkg::COL_W;
  localparam int ROW_W  = sgdt_pkg::ROW_W;
  localparam int PIX_W  = sgdt_pkg::PIX_W;
  localparam int WCFG_W = sgdt_pkg::WCFG_W;
  localparam int HCFG_W = sgdt_pkg::HCFG_W;

  localparam logic [WCFG_W-1:0] W_MIN = WCFG_W'(sgdt_pkg::MIN_DIM);
  localparam logic [WCFG_W-1:0] W_MAX = WCFG_W'(sgdt_pkg::MAX_WIDTH);
  localparam logic [HCFG_W-1:0] H_MIN = HCFG_W'(sgdt_pkg::MIN_DIM);
  localparam logic [HCFG_W-1:0] H_MAX = HCFG_W'(sgdt_pkg::MAX_HEIGHT);

  logic                  accept;
  logic [WCFG_W-1:0]     w_eff;
  logic [HCFG_W-1:0]     h_eff;
  logic [COL_W-1:0]      col_r, col_nxt, col_cur;
  logic [ROW_W-1:0]      row_r, row_nxt, row_cur;
  logic [WCFG_W-1:0]     col_inc;
  logic [HCFG_W-1:0]     row_inc;
  logic                  emit_cur;
  logic [sgdt_pkg::MQ_CW+1:0] pending;

  // stage 1: line store read in flight
  logic                  s1_v_r;
  logic                  s1_emit_r;
  logic [PIX_W-1:0]      s1_px_r;
  logic [COL_W-1:0]      s1_col_r;
  logic [ROW_W-1:0]      s1_crow_r;
  logic [COL_W-1:0]      s1_ccol_r;

  logic [sgdt_pkg::LINE_W-1:0] line_rd;
  logic [PIX_W-1:0]      up, mid;

  // last line store write, forwarded when the next read hits the same column
  logic                  byp_v_r;
  logic [COL_W-1:0]      byp_col_r;
  logic [PIX_W-1:0]      byp_up_r;
  logic [PIX_W-1:0]      byp_mid_r;
  logic                  byp_hit;

  logic [8:0][PIX_W-1:0] win_r, win_nxt;
  logic                  emit_r;
  logic [ROW_W-1:0]      crow_r;
  logic [COL_W-1:0]      ccol_r;

  always_comb begin
    if (image_width < W_MIN) begin
      w_eff = W_MIN;
    end else if (image_width > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = image_width;
    end
    if (image_height < H_MIN) begin
      h_eff = H_MIN;
    end else if (image_height > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = image_height;
    end
  end

  // count every window that may still land in the queue
  assign pending = (sgdt_pkg::MQ_CW+2)'(mq_level)
                 + (sgdt_pkg::MQ_CW+2)'(s1_v_r & s1_emit_r)
                 + (sgdt_pkg::MQ_CW+2)'(emit_r);
  assign in_full = (pending >= (sgdt_pkg::MQ_CW+2)'(sgdt_pkg::MQ_DEPTH));
  assign accept  = in_push & ~in_full;

  always_comb begin
    col_cur  = in_data.frame_start ? '0 : col_r;
    row_cur  = in_data.frame_start ? '0 : row_r;
    emit_cur = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    col_inc  = WCFG_W'(col_cur) + WCFG_W'(1);
    row_inc  = HCFG_W'(row_cur) + HCFG_W'(1);
    col_nxt  = col_inc[COL_W-1:0];
    row_nxt  = row_cur;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
    end else begin
      s1_v_r    <= accept;
      s1_emit_r <= accept & emit_cur;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_data.pixel;
      s1_col_r  <= col_cur;
      s1_crow_r <= row_cur - ROW_W'(1);
      s1_ccol_r <= col_cur - COL_W'(1);
    end
  end

  sgdt_ram #(
    .WIDTH (sgdt_pkg::LINE_W),
    .DEPTH (sgdt_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata ({mid, s1_px_r}),
    .re    (accept),
    .raddr (col_cur),
    .rdata (line_rd)
  );

  assign byp_hit = byp_v_r && (byp_col_r == s1_col_r);
  assign up      = byp_hit ? byp_up_r  : line_rd[2*PIX_W-1:PIX_W];
  assign mid     = byp_hit ? byp_mid_r : line_rd[PIX_W-1:0];

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
      emit_r  <= 1'b0;
      win_r   <= '0;
    end else begin
      emit_r <= s1_v_r & s1_emit_r;
      if (s1_v_r) begin
        byp_v_r <= 1'b1;
        win_r   <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      byp_col_r <= s1_col_r;
      byp_up_r  <= mid;
      byp_mid_r <= s1_px_r;
      crow_r    <= s1_crow_r;
      ccol_r    <= s1_ccol_r;
    end
  end

  assign mq_push            = emit_r;
  assign mq_item.pix        = win_r;
  assign mq_item.center_row = crow_r;
  assign mq_item.center_col = ccol_r;

endmodule
`default_nettype wire

@@ hdl/sgdt_win_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgdt_win_queue
// Short first-word-fall-through queue of windows between front and back.
// ----------------------------------------------------------------------------
module sgdt_win_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire sgdt_pkg::win_item_t         push_item,
  input  wire logic                        pop,
  output logic                             valid,
  output sgdt_pkg::win_item_t              head_item,
  output logic [sgdt_pkg::MQ_CW-1:0]       level
);

  localparam int AW = sgdt_pkg::MQ_AW;
  localparam int CW = sgdt_pkg::MQ_CW;

  sgdt_pkg::win_item_t mem_r [sgdt_pkg::MQ_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] level_r;
  logic          do_pop;

  assign valid     = (level_r != '0);
  assign do_pop    = pop & valid;
  assign head_item = mem_r[rd_ptr_r];
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      level_r <= level_r + CW'(push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sgdt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgdt_back
// Sobel sums, squared magnitude and double threshold, with the result queue.
// ----------------------------------------------------------------------------
module sgdt_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         mq_valid,
  input  wire sgdt_pkg::win_item_t          mq_item,
  output logic                              mq_pop,
  input  wire logic [sgdt_pkg::THR_W-1:0]   low_thr_sq,
  input  wire logic [sgdt_pkg::THR_W-1:0]   high_thr_sq,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output sgdt_pkg::out_item_t               out_data
);

  localparam int PIX_W  = sgdt_pkg::PIX_W;
  localparam int GRAD_W = sgdt_pkg::GRAD_W;
  localparam int SUM_W  = PIX_W + 2;
  localparam int SQ_W   = sgdt_pkg::SQ_W;
  localparam int MAG_W  = sgdt_pkg::MAG_W;
  localparam int ROW_W  = sgdt_pkg::ROW_W;
  localparam int COL_W  = sgdt_pkg::COL_W;
  localparam int AW     = sgdt_pkg::OQ_AW;
  localparam int CW     = sgdt_pkg::OQ_CW;

  logic [CW+1:0] oq_pending;
  logic          take;

  logic [8:0][PIX_W-1:0] w;
  logic [SUM_W-1:0]      x_pos, x_neg, y_pos, y_neg;

  logic                     b1_v_r, b2_v_r, b3_v_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic signed [2*GRAD_W-1:0] gxx, gyy;
  logic [SQ_W-1:0]          gxx_r, gyy_r;
  logic [MAG_W-1:0]         mag_r;
  logic [ROW_W-1:0]         b1_row_r, b2_row_r, b3_row_r;
  logic [COL_W-1:0]         b1_col_r, b2_col_r, b3_col_r;
  logic [sgdt_pkg::CLS_W-1:0] cls;
  sgdt_pkg::out_item_t      res;

  sgdt_pkg::out_item_t oq_mem_r [sgdt_pkg::OQ_DEPTH];
  logic [AW-1:0] oq_wr_r, oq_rd_r;
  logic [CW-1:0] oq_level_r;
  logic          oq_pop;

  // reserve a result slot for everything in the arithmetic pipe
  assign oq_pending = (CW+2)'(oq_level_r) + (CW+2)'(b1_v_r)
                    + (CW+2)'(b2_v_r) + (CW+2)'(b3_v_r);
  assign take   = mq_valid && (oq_pending < (CW+2)'(sgdt_pkg::OQ_DEPTH));
  assign mq_pop = take;

  assign w     = mq_item.pix;
  assign x_pos = SUM_W'(w[2]) + {1'b0, w[5], 1'b0} + SUM_W'(w[8]);
  assign x_neg = SUM_W'(w[0]) + {1'b0, w[3], 1'b0} + SUM_W'(w[6]);
  assign y_pos = SUM_W'(w[6]) + {1'b0, w[7], 1'b0} + SUM_W'(w[8]);
  assign y_neg = SUM_W'(w[0]) + {1'b0, w[1], 1'b0} + SUM_W'(w[2]);

  assign gxx = gx_r * gx_r;
  assign gyy = gy_r * gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      b1_v_r <= take;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    gx_r     <= $signed({1'b0, x_pos}) - $signed({1'b0, x_neg});
    gy_r     <= $signed({1'b0, y_pos}) - $signed({1'b0, y_neg});
    b1_row_r <= mq_item.center_row;
    b1_col_r <= mq_item.center_col;
    gxx_r    <= gxx[SQ_W-1:0];
    gyy_r    <= gyy[SQ_W-1:0];
    b2_row_r <= b1_row_r;
    b2_col_r <= b1_col_r;
    mag_r    <= MAG_W'(gxx_r) + MAG_W'(gyy_r);
    b3_row_r <= b2_row_r;
    b3_col_r <= b2_col_r;
  end

  assign cls = sgdt_pkg::CLS_W'(mag_r > low_thr_sq)
             + sgdt_pkg::CLS_W'(mag_r > high_thr_sq);

  always_comb begin
    res.edge_class   = cls;
    res.magnitude_sq = mag_r;
    res.center_row   = b3_row_r;
    res.center_col   = b3_col_r;
  end

  assign out_empty = (oq_level_r == '0);
  assign oq_pop    = out_pop & ~out_empty;
  assign out_data  = oq_mem_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_level_r <= '0;
    end else begin
      if (b3_v_r) begin
        oq_wr_r <= oq_wr_r + AW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + AW'(1);
      end
      oq_level_r <= oq_level_r + CW'(b3_v_r) - CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b3_v_r) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sobel_gradient_double_threshold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_gradient_double_threshold
// Streaming 3x3 Sobel squared magnitude with low/high threshold classes.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock while in_full is low, and for
// every interior centre one result comes out carrying the squared gradient
// magnitude, the edge class (0 none, 1 above one limit, 2 above both) and the
// centre position; border pixels produce nothing. The line store RAM takes
// one read and one write per accepted pixel, so it keeps up with one pixel
// per clock. A result passes from the accepted pixel below and right of its
// centre through the line store read stage, the window register, the window
// queue, three arithmetic pipe registers and the output queue; it waits in
// the window queue while the output queue has no free slot. The line store
// is not cleared after reset; its rows hold valid data once written by a
// frame. Configuration writes are taken at any time (cfg_ready is always
// high) but belong between frames while the block is drained.
// ----------------------------------------------------------------------------
module sobel_gradient_double_threshold (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  input  wire sgdt_pkg::in_item_t                 in_data,
  output logic                                    in_full,
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output sgdt_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sgdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sgdt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [sgdt_pkg::WCFG_W-1:0] image_width_r;
  logic [sgdt_pkg::HCFG_W-1:0] image_height_r;
  logic [sgdt_pkg::THR_W-1:0]  low_thr_r;
  logic [sgdt_pkg::THR_W-1:0]  high_thr_r;

  logic                        mq_push;
  sgdt_pkg::win_item_t         mq_in;
  logic                        mq_pop;
  logic                        mq_valid;
  sgdt_pkg::win_item_t         mq_head;
  logic [sgdt_pkg::MQ_CW-1:0]  mq_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= sgdt_pkg::RST_IMAGE_WIDTH;
      image_height_r <= sgdt_pkg::RST_IMAGE_HEIGHT;
      low_thr_r      <= sgdt_pkg::RST_LOW_THR_SQ;
      high_thr_r     <= sgdt_pkg::RST_HIGH_THR_SQ;
    end else if (cfg_valid) begin
      case (cfg_index)
        sgdt_pkg::REG_IMAGE_WIDTH: begin
          image_width_r <= cfg_data[sgdt_pkg::WCFG_W-1:0];
        end
        sgdt_pkg::REG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_data[sgdt_pkg::HCFG_W-1:0];
        end
        sgdt_pkg::REG_LOW_THR_SQ: begin
          low_thr_r <= cfg_data[sgdt_pkg::THR_W-1:0];
        end
        sgdt_pkg::REG_HIGH_THR_SQ: begin
          high_thr_r <= cfg_data[sgdt_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sgdt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data      (in_data),
    .in_full      (in_full),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .mq_level     (mq_level),
    .mq_push      (mq_push),
    .mq_item      (mq_in)
  );

  sgdt_win_queue u_win_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mq_push),
    .push_item (mq_in),
    .pop       (mq_pop),
    .valid     (mq_valid),
    .head_item (mq_head),
    .level     (mq_level)
  );

  sgdt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mq_valid    (mq_valid),
    .mq_item     (mq_head),
    .mq_pop      (mq_pop),
    .low_thr_sq  (low_thr_r),
    .high_thr_sq (high_thr_r),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

@@ sim/tb_sobel_gradient_double_threshold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sobel_gradient_double_threshold
// Self-checking bench for the streaming Sobel double threshold block.
// ----------------------------------------------------------------------------
// A short table of hand-built 3x3 frames checks the reset thresholds, the
// width and height clamps, a restart in mid-frame and every edge class. Then
// random frames run under changing geometry and thresholds, with the sender
// and the receiver idling in turns, and one pass at the widest row. Every
// pixel is fed to an in-bench model of the window and the arithmetic, and
// each result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sobel_gradient_double_threshold;
  timeunit 1ns;
  timeprecision 1ps;

  import sgdt_pkg::*;

  localparam int DRAIN_CYCLES     = 24;
  localparam int IDLE_LIMIT       = 4000;
  localparam int BIG_FRAME_PIXELS = MAX_WIDTH + 48;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
    logic             typed;
    out_item_t        res;
  } dir_row_t;

  localparam out_item_t NO_EDGE = '0;

  // 3x3 frames after the clamp; thresholds still at their reset values
  localparam dir_row_t DIRECTED [28] = '{
    '{8'd255, 1'b0, 1'b0, NO_EDGE},
    // flat black frame, restarted after one stray pixel
    '{8'd0,   1'b1, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b1, '{2'd0, 21'd0, 12'd1, 10'd1}},
    // largest magnitude the window allows, frame follows by wrap
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd255, 1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd128, 1'b0, 1'b0, NO_EDGE},
    '{8'd255, 1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd255, 1'b0, 1'b0, NO_EDGE},
    '{8'd255, 1'b0, 1'b1, '{2'd2, 21'd1300500, 12'd1, 10'd1}},
    // faint vertical edge, weak class only
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd25,  1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd25,  1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd0,   1'b0, 1'b0, NO_EDGE},
    '{8'd25,  1'b0, 1'b1, '{2'd1, 21'd10000, 12'd1, 10'd1}}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // model of the block: line stores, window, position and registers
  logic [PIX_W-1:0]  upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_line [MAX_WIDTH];
  logic [PIX_W-1:0]  win3 [9];
  int                row_pos = 0;
  int                col_pos = 0;
  logic [WCFG_W-1:0] width_reg  = RST_IMAGE_WIDTH;
  logic [HCFG_W-1:0] height_reg = RST_IMAGE_HEIGHT;
  logic [THR_W-1:0]  low_reg    = RST_LOW_THR_SQ;
  logic [THR_W-1:0]  high_reg   = RST_HIGH_THR_SQ;

  out_item_t        edges_in_flight [$];
  out_item_t        oldest_edge;
  int               mismatches    = 0;
  int               quiet_cycles  = 0;
  int               send_idle_pct = 0;
  int               stall_pct     = 0;
  bit               restart_due   = 1'b0;
  logic [PIX_W-1:0] last_pixel    = '0;

  sobel_gradient_double_threshold i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clamp_dim(input int v, input int hi);
    return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = val[WCFG_W-1:0];
      REG_IMAGE_HEIGHT: height_reg = val[HCFG_W-1:0];
      REG_LOW_THR_SQ:   low_reg    = val[THR_W-1:0];
      REG_HIGH_THR_SQ:  high_reg   = val[THR_W-1:0];
      default: ;
    endcase
  endfunction

  // one pixel through the window; returns 1 when a centre is reported
  function automatic bit sobel_classify(input in_item_t px_in, output out_item_t res);
    int               w_eff;
    int               h_eff;
    int               col;
    int               row;
    int               gx;
    int               gy;
    int unsigned      mag;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    bit               hit;
    w_eff = clamp_dim(int'(width_reg), MAX_WIDTH);
    h_eff = clamp_dim(int'(height_reg), MAX_HEIGHT);
    if (px_in.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    up  = '0;
    mid = '0;
    if (col < MAX_WIDTH) begin
      up  = upper_line[col];
      mid = middle_line[col];
      upper_line[col]  = mid;
      middle_line[col] = px_in.pixel;
    end
    for (int r = 0; r < 3; r++) begin
      win3[r*3]   = win3[r*3+1];
      win3[r*3+1] = win3[r*3+2];
    end
    win3[2] = up;
    win3[5] = mid;
    win3[8] = px_in.pixel;
    res = '0;
    hit = 1'b0;
    if (row >= 2 && col >= 2) begin
      gx = (int'(win3[2]) + 2 * int'(win3[5]) + int'(win3[8]))
         - (int'(win3[0]) + 2 * int'(win3[3]) + int'(win3[6]));
      gy = (int'(win3[6]) + 2 * int'(win3[7]) + int'(win3[8]))
         - (int'(win3[0]) + 2 * int'(win3[1]) + int'(win3[2]));
      mag = gx * gx + gy * gy;
      res.edge_class   = {1'b0, mag > low_reg} + {1'b0, mag > high_reg};
      res.magnitude_sq = MAG_W'(mag);
      res.center_row   = ROW_W'(row - 1);
      res.center_col   = COL_W'(col - 1);
      hit = 1'b1;
    end
    col++;
    if (col >= w_eff) begin
      col = 0;
      row++;
      if (row >= h_eff) row = 0;
    end
    col_pos = col;
    row_pos = row;
    return hit;
  endfunction

  // mostly noise, some hard black and white, some smooth ramps
  function automatic logic [PIX_W-1:0] next_pixel();
    int v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom_range(0, 255);
      2:    v = $urandom_range(0, 1) ? 255 : 0;
      default: begin
        v = int'(last_pixel) + int'($urandom_range(0, 16)) - 8;
        v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
      end
    endcase
    last_pixel = PIX_W'(v);
    return last_pixel;
  endfunction

  function automatic void set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 48; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 48; end
      3:       begin send_idle_pct = 27; stall_pct = 27; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endfunction

  task automatic settle();
    while (edges_in_flight.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
    int old_w;
    settle();
    old_w = clamp_dim(int'(width_reg), MAX_WIDTH);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_LOW_THR_SQ, lo);
    write_reg(REG_HIGH_THR_SQ, hi);
    cfg_valid <= 1'b0;
    // a wider row would read line store columns the frame never filled
    if (clamp_dim(int'(width_reg), MAX_WIDTH) > old_w) restart_due = 1'b1;
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] pixel, input logic fs,
                            input bit typed, input out_item_t typed_res);
    in_item_t  beat;
    out_item_t res;
    bit        hit;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    beat.pixel       = pixel;
    beat.frame_start = fs | restart_due;
    restart_due      = 1'b0;
    in_push <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_full);
    hit = sobel_classify(beat, res);
    if (typed) edges_in_flight = {edges_in_flight, typed_res};
    else if (hit) edges_in_flight = {edges_in_flight, res};
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                           input int pixels, input int mode);
    configure(w, h, lo, hi);
    set_idling(mode);
    for (int i = 0; i < pixels; i++) begin
      push_pixel(next_pixel(), $urandom_range(0, 79) == 0, 1'b0, NO_EDGE);
    end
    in_push <= 1'b0;
  endtask

  // result side: random pop, compare each beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (edges_in_flight.size() == 0) begin
        $error("result beat at row %0d col %0d with nothing outstanding",
               out_data.center_row, out_data.center_col);
        mismatches++;
      end else begin
        oldest_edge = edges_in_flight.pop_front();
        if (out_data.edge_class !== oldest_edge.edge_class) begin
          $error("edge_class: expected %0d, got %0d",
                 oldest_edge.edge_class, out_data.edge_class);
          mismatches++;
        end
        if (out_data.magnitude_sq !== oldest_edge.magnitude_sq) begin
          $error("magnitude_sq: expected %0d, got %0d",
                 oldest_edge.magnitude_sq, out_data.magnitude_sq);
          mismatches++;
        end
        if (out_data.center_row !== oldest_edge.center_row) begin
          $error("center_row: expected %0d, got %0d",
                 oldest_edge.center_row, out_data.center_row);
          mismatches++;
        end
        if (out_data.center_col !== oldest_edge.center_col) begin
          $error("center_col: expected %0d, got %0d",
                 oldest_edge.center_col, out_data.center_col);
          mismatches++;
        end
      end
    end
    out_pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles where no beat moves on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int               w;
    int               h;
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    foreach (win3[i]) win3[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // geometry below range clamps to 3x3; thresholds keep reset values
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    cfg_valid <= 1'b0;
    set_idling(0);
    foreach (DIRECTED[i]) begin
      push_pixel(DIRECTED[i].pixel, DIRECTED[i].frame_start, DIRECTED[i].typed,
                 DIRECTED[i].res);
    end
    in_push <= 1'b0;

    run_phase(21'd5, 21'd4, 21'd0, 21'h1FFFFF, 150, 0);
    // low above high: flags simply add
    run_phase(21'd3, 21'd3, 21'h1FFFFF, 21'd0, 150, 1);
    for (int k = 0; k < 8; k++) begin
      w  = $urandom_range(0, 14);
      h  = $urandom_range(0, 9);
      lo = THR_W'($urandom_range(0, 150000));
      hi = THR_W'($urandom_range(0, 700000));
      // junk above the register width must be dropped
      run_phase((CFG_DATA_W'($urandom) & 21'h1FF800) | CFG_DATA_W'(w),
                (CFG_DATA_W'($urandom) & 21'h1FE000) | CFG_DATA_W'(h),
                lo, hi, 50, k % 4);
    end
    // widest and tallest settings clamp to MAX_WIDTH and MAX_HEIGHT
    run_phase(21'd2047, 21'd8191, 21'd4900, 21'd300000, BIG_FRAME_PIXELS, 3);
    // narrower rows while the counters sit mid-frame
    run_phase(21'd4, 21'd3, 21'd1000, 21'd50000, 100, 2);

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
